@@ hdl/sbus_frame_receiver_top_defines.svh @@
// Assertion macros for the SBUS frame receiver.
// No dependencies.
`ifndef SBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SBR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBR_ASSERT(label, prop, msg)
`define SBR_ASSERT_RST(label, prop, msg)
`endif
`endif

@@ hdl/sbr_pkg.sv @@
// Shared types, constants and functions of the SBUS frame receiver.
// No dependencies.
package sbr_pkg;
  localparam int NumChannelsDef = 18;
  localparam logic [7:0] HdrByte = 8'h0F;
  localparam logic [7:0] FooterA = 8'h00;
  localparam logic [7:0] FooterB = 8'h04;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam int FrameLen = 25;
  localparam int CrcLen = 23;
  localparam logic [31:0] GapLimit = 32'd30;
  localparam logic [11:0] ScaleOfs = 12'd875;
  localparam logic [11:0] SwitchVal = 12'd998;

  // Job handed from front to back: one per completed frame.
  typedef struct packed {
    logic        ok;
    logic [31:0] now;
    logic [175:0] bits;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOST,
    BK_EMIT
  } bk_state_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // raw*1000/1600 = raw*5/8
  function automatic logic [11:0] scale(input logic [10:0] raw);
    logic [13:0] p;
    p = {raw, 2'b00} + {3'b000, raw};
    return 12'(p[13:3]) + ScaleOfs;
  endfunction
endpackage

@@ hdl/sbus_frame_receiver_top.sv @@
// Channel      | Dir | Payload
// s_axis       | in  | tdata: data_byte[7:0], time_ms[39:8]
// m_axis       | out | tdata: channel_index, channel_value, failsafe, counters; tuser frame_ok
// crc_check_en | in  | one-bit config register, reset 1
// One byte per cycle in; a good frame's 16/18 results leave one per cycle while m_axis
// is ready, after a lost-frame step in the back end; a bad frame gives one beat.
// Bytes stall only while a finished frame waits for the back end. Reset is synchronous on rst.
// Depends on sbr_pkg, sbr_front, sbr_back.
module sbus_frame_receiver_top #(
  parameter int NUM_CHANNELS = sbr_pkg::NumChannelsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         crc_check_enable_we,
  input  logic         crc_check_enable_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // data_byte, time_ms
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // channel_index, channel_value, failsafe,
                                       // good_frames, bad_frames, missed_frames, zero pad
  output logic         m_axis_tlast,
  output logic         m_axis_tuser    // frame_ok
);
  import sbr_pkg::*;

  logic crc_en;
  logic job_valid, job_ready;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) crc_en <= 1'b1;
    else if (crc_check_enable_we) crc_en <= crc_check_enable_wdata;
  end

  sbr_front u_front (
    .clk, .rst, .crc_en,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata[7:0]), .time_ms(s_axis_tdata[39:8]),
    .job_valid, .job_ready, .job
  );

  sbr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );
endmodule

@@ hdl/sbr_front.sv @@
// Front end: header hunt, frame capture, CRC and footer check.
// Depends on sbr_pkg.
module sbr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          crc_en,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   time_ms,
  output logic          job_valid,
  input  logic          job_ready,
  output sbr_pkg::job_t job
);
  import sbr_pkg::*;
  `include "sbus_frame_receiver_top_defines.svh"

  logic [4:0]   pos;
  logic [7:0]   crc;
  logic [175:0] bits;
  logic [7:0]   b23;
  logic         take;
  logic         done;

  assign in_ready = !job_valid || job_ready;
  assign take = in_valid && in_ready;
  assign done = take && (pos == 5'(FrameLen - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= done || (job_valid && !job_ready);
      if (take) begin
        if (pos == 5'd0) begin
          if (data_byte == HdrByte) begin
            pos <= 5'd1;
            crc <= crc_byte(8'h00, data_byte);
          end
        end else begin
          if (pos < 5'(CrcLen)) crc <= crc_byte(crc, data_byte);
          if (pos >= 5'd1 && pos <= 5'd22) bits[(pos - 5'd1) * 8 +: 8] <= data_byte;
          if (pos == 5'(CrcLen)) b23 <= data_byte;
          if (done) begin
            pos <= '0;
            job.ok <= ((data_byte == FooterA) || (data_byte == FooterB)) &&
                      (!crc_en || (crc == b23));
            job.now <= time_ms;
            job.bits <= bits;
          end else begin
            pos <= pos + 5'd1;
          end
        end
      end
    end
  end

  `SBR_ASSERT(a_pos_range, pos < 5'(FrameLen), "byte position out of range")
  `SBR_ASSERT(a_job_hold, job_valid && !job_ready |=> job_valid, "job dropped")
  `SBR_ASSERT(a_done_job, done |=> job_valid, "finished frame not handed on")
endmodule

@@ hdl/sbr_back.sv @@
// Back end: counters, lost-frame estimate, channel unpack and scaling.
// Depends on sbr_pkg.
module sbr_back #(
  parameter int NUM_CHANNELS = sbr_pkg::NumChannelsDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  sbr_pkg::job_t job,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,
  output logic          m_axis_tlast,
  output logic          m_axis_tuser
);
  import sbr_pkg::*;
  `include "sbus_frame_receiver_top_defines.svh"

  localparam logic [4:0] LastCh = 5'(NUM_CHANNELS > 17 ? 17 : 15);

  bk_state_t    state, state_next;
  logic [4:0]   ch;
  logic [31:0]  good, bad, lost, last_time, gap;
  logic         fs;
  logic [175:0] bits;
  logic [31:0]  gap_q;
  logic [27:0]  div20;
  logic [11:0]  val;
  logic [10:0]  raw;
  logic         out_free;
  logic         out_load;
  logic         fs_hit;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == BK_IDLE && job_ready && !job.ok) ||
                    (state == BK_EMIT && out_free);
  assign gap = job.now - last_time;
  assign raw = bits[ch * 11 +: 11];
  assign val = (ch >= 5'd16) ? SwitchVal : scale(raw);
  // raw of 0 or 1 on any of channels 0 to 3 scales to 875 or less
  assign fs_hit = ~|job.bits[10:1] || ~|job.bits[21:12] ||
                  ~|job.bits[32:23] || ~|job.bits[43:34];
  // gap/20 = (gap>>2)/5, reciprocal of 5 on 30 bits
  assign div20 = 28'(({32'd0, gap_q >> 2} * 64'hCCCCCCCD) >> 34);

  always_comb begin
    state_next = state;
    job_ready = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid && out_free) begin
          job_ready = 1'b1;
          state_next = job.ok ? BK_LOST : BK_IDLE;
        end
      end
      BK_LOST: state_next = BK_EMIT;
      BK_EMIT: if (out_free && ch == LastCh) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      good <= '0; bad <= '0; lost <= '0; last_time <= '0; fs <= 1'b0;
      m_axis_tvalid <= 1'b0;
      ch <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      unique case (state)
        BK_IDLE: if (job_ready) begin
          bits <= job.bits;
          ch <= '0;
          gap_q <= (last_time != 0 && gap > GapLimit) ? gap : 32'd0;
          if (job.ok) begin
            good <= good + 32'd1;
            last_time <= job.now;
            if (fs_hit) fs <= 1'b1;
          end else begin
            bad <= bad + 32'd1;
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= 1'b0;
            m_axis_tlast <= 1'b1;
            m_axis_tdata <= {6'd0, lost, bad + 32'd1, good, fs, 12'd0, 5'd0};
          end
        end
        BK_LOST: if (gap_q != 0) lost <= lost + 32'(div20) - 32'd1;
        BK_EMIT: if (out_free) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tuser <= 1'b1;
          m_axis_tlast <= (ch == LastCh);
          m_axis_tdata <= {6'd0, lost, bad, good, fs, val, ch};
          ch <= ch + 5'd1;
        end
        default: ;
      endcase
    end
  end

  `SBR_ASSERT(a_ch_range, state == BK_EMIT |-> ch <= LastCh, "channel index overrun")
  `SBR_ASSERT(a_fs_sticky, $past(fs) |-> fs, "failsafe cleared")
  `SBR_ASSERT(a_no_take_busy, job_ready |-> state == BK_IDLE, "job taken while busy")
endmodule

@@ test/sbus_frame_receiver_top_tb.sv @@
// Testbench for sbus_frame_receiver_top: drives SBUS bytes and checks decoded channel beats.
// Depends on sbr_pkg and the receiver RTL; a small scoreboard class predicts every result beat.
module sbus_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit        ok;
    bit [4:0]  idx;
    bit [11:0] val;
    bit        fs;
    bit        lst;
    bit [31:0] good;
    bit [31:0] bad;
    bit [31:0] lost;
  } chan_res_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  class frame_scoreboard;
    bit        crc_en = 1;
    int        pos = 0;
    bit [7:0]  frame[25];
    bit [7:0]  crc = 0;
    bit [31:0] last_time = 0, good = 0, bad = 0, lost = 0;
    bit        fs = 0;
    chan_res_t pending[$];

    function bit [7:0] crc8(bit [7:0] c, bit [7:0] b);
      bit [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) r = r[7] ? ((r << 1) ^ 8'h31) : (r << 1);
      return r;
    endfunction

    function void note_byte(bit [7:0] b, bit [31:0] now);
      bit [11:0] vals[18];
      bit [31:0] gap;
      bit [23:0] w;
      int        bitn, ix;
      chan_res_t r;
      if (pos == 0) begin
        if (b != sbr_pkg::HdrByte) return;
        frame[0] = b;
        crc = crc8(0, b);
        pos = 1;
        return;
      end
      frame[pos] = b;
      if (pos < 23) crc = crc8(crc, b);
      pos++;
      if (pos < 25) return;
      pos = 0;
      if (!((frame[24] == 8'h00 || frame[24] == 8'h04) && (!crc_en || crc == frame[23])))
          begin
        bad++;
        r = '{0, 0, 0, fs, 1, good, bad, lost};
        pending.push_back(r);
        return;
      end
      good++;
      gap = now - last_time;
      if (last_time != 0 && gap > 30) lost += gap / 20 - 1;
      last_time = now;
      for (int i = 0; i < 16; i++) begin
        bitn = i * 11;
        ix = 1 + bitn / 8;
        w = {(ix + 2 < 25) ? frame[ix + 2] : 8'h00, frame[ix + 1], frame[ix]};
        vals[i] = 12'(((w >> (bitn % 8)) & 24'h7FF) * 1000 / 1600 + 875);
      end
      vals[16] = 998;
      vals[17] = 998;
      for (int i = 0; i < 4; i++) if (vals[i] <= 875) fs = 1;
      for (int i = 0; i < 18; i++) begin
        r = '{1, 5'(i), vals[i], fs, i == 17, good, bad, lost};
        pending.push_back(r);
      end
    endfunction

    task check_beat(chan_res_t g);
      chan_res_t e;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (g.ok != e.ok) report($sformatf("frame_ok %0d exp %0d", g.ok, e.ok));
      if (g.idx != e.idx) report($sformatf("channel_index %0d exp %0d", g.idx, e.idx));
      if (g.val != e.val) report($sformatf("channel_value %0d exp %0d", g.val, e.val));
      if (g.fs != e.fs) report($sformatf("failsafe %0d exp %0d", g.fs, e.fs));
      if (g.lst != e.lst) report($sformatf("last %0d exp %0d", g.lst, e.lst));
      if (g.good != e.good) report($sformatf("good_frames %0d exp %0d", g.good, e.good));
      if (g.bad != e.bad) report($sformatf("bad_frames %0d exp %0d", g.bad, e.bad));
      if (g.lost != e.lost) report($sformatf("missed_frames %0d exp %0d", g.lost, e.lost));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         crc_check_enable_we = 0;
  logic         crc_check_enable_wdata = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;   // data_byte, time_ms
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [119:0] m_axis_tdata;        // channel_index, channel_value, failsafe, good, bad, missed
  logic         m_axis_tlast;
  logic         m_axis_tuser;        // frame_ok

  sbus_frame_receiver_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  frame_scoreboard sb = new();
  int        send_idle = 0, recv_stall = 0, hold_cycles = 0;
  bit [31:0] clock_ms = 1;

  always @(posedge clk) begin
    chan_res_t g;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      g.ok = m_axis_tuser;
      g.idx = m_axis_tdata[4:0];
      g.val = m_axis_tdata[16:5];
      g.fs = m_axis_tdata[17];
      g.lst = m_axis_tlast;
      g.good = m_axis_tdata[49:18];
      g.bad = m_axis_tdata[81:50];
      g.lost = m_axis_tdata[113:82];
      sb.check_beat(g);
    end
    if (rst) m_axis_tready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_byte(input bit [7:0] b, input bit [31:0] now);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {now, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b, now);
  endtask

  int n_items = 0;

  // good or broken frame; kind 0 good, 1 bad crc, 2 bad footer, 3 failsafe low
  task automatic send_frame(input int kind, input bit [31:0] now, input bit max_ch = 0);
    bit [7:0] f[25];
    bit [7:0] c;
    f[0] = sbr_pkg::HdrByte;
    for (int i = 1; i < 23; i++) f[i] = max_ch ? 8'hFF : 8'($urandom);
    if (kind == 3) begin
      f[1] = 0;
      f[2][2:0] = 0;
    end
    c = 0;
    for (int i = 0; i < 23; i++) c = sb.crc8(c, f[i]);
    f[23] = (kind == 1) ? ~c : c;
    f[24] = (kind == 2) ? 8'($urandom_range(255, 5)) : ($urandom_range(1) ? 8'h04 : 8'h00);
    for (int i = 0; i < 25; i++) begin
      send_byte(f[i], now);
      n_items++;
    end
  endtask

  task automatic drain_and_cfg(input bit v);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    crc_check_enable_we <= 1;
    crc_check_enable_wdata <= v;
    @(posedge clk);
    crc_check_enable_we <= 0;
    sb.crc_en = v;
  endtask

  task automatic random_phase(input int items);
    int target;
    target = n_items + items;
    while (n_items < target) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom), clock_ms);
        n_items++;
      end else begin
        clock_ms += $urandom_range(3) == 0 ? $urandom_range(200) : 20;
        send_frame($urandom_range(9) < 7 ? 0 : $urandom_range(3, 1), clock_ms);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: noise while hunting, good, max channels, failsafe, bad crc, bad footer
    send_byte(8'hFF, 0);
    send_byte(8'h00, 0);
    n_items += 2;
    send_frame(0, 32'd0, 1);
    send_frame(0, 32'd100);
    send_frame(3, 32'hFFFF_FFF0);
    send_frame(0, 32'd5);
    send_frame(1, 32'd25);
    send_frame(2, 32'd45);
    drain_and_cfg(0);
    send_frame(1, 32'd65);
    drain_and_cfg(1);
    recv_stall = 78;
    random_phase(36);
    drain_and_cfg(0);
    recv_stall = 0;
    send_idle = 78;
    random_phase(36);
    send_idle = 6;
    recv_stall = 6;
    drain_and_cfg(1);
    random_phase(36);
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 400;
    random_phase(36);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sbr_pkg.sv
hdl/sbr_front.sv
hdl/sbr_back.sv
hdl/sbus_frame_receiver_top.sv
test/sbus_frame_receiver_top_tb.sv
